[sv/gof_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package gof_pkg;

	localparam int SAMPLE_BITS  = 16;
	localparam int COL_BITS     = 10;
	localparam int MAX_WIDTH    = 1 << COL_BITS;
	localparam int RING_ROWS    = 17;
	localparam int RING_BITS    = 5;
	localparam int ADDR_BITS    = RING_BITS + COL_BITS;
	localparam int STORE_DEPTH  = RING_ROWS * MAX_WIDTH;
	localparam int WIN_BEFORE   = 7;
	localparam int CORDIC_STEPS = 23;
	localparam int ACC_BITS     = 40;
	localparam int VEC_BITS     = 45;
	localparam int ANG_BITS     = 26;
	localparam int CFG_BITS     = 13;
	localparam int CFG_IDX_BITS = 2;

	localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = 2'd1;

	localparam logic signed [ANG_BITS-1:0] DEG90_U  = 26'sd5898240;
	localparam logic signed [ANG_BITS-1:0] DEG180_U = 26'sd11796480;
	localparam logic signed [ANG_BITS-1:0] DEG360_U = 26'sd23592960;
	localparam logic signed [17:0]         OUT90    = 18'sd23040;

	// atan(2^-i) in 2^-16 degree
	function automatic logic signed [ANG_BITS-1:0] atan_entry(input logic [4:0] i);
		logic signed [ANG_BITS-1:0] v;
		begin
			case (i)
				5'd0:  v = 26'sd2949120;
				5'd1:  v = 26'sd1740967;
				5'd2:  v = 26'sd919879;
				5'd3:  v = 26'sd466945;
				5'd4:  v = 26'sd234379;
				5'd5:  v = 26'sd117304;
				5'd6:  v = 26'sd58666;
				5'd7:  v = 26'sd29335;
				5'd8:  v = 26'sd14668;
				5'd9:  v = 26'sd7334;
				5'd10: v = 26'sd3667;
				5'd11: v = 26'sd1833;
				5'd12: v = 26'sd917;
				5'd13: v = 26'sd458;
				5'd14: v = 26'sd229;
				5'd15: v = 26'sd115;
				5'd16: v = 26'sd57;
				5'd17: v = 26'sd29;
				5'd18: v = 26'sd14;
				5'd19: v = 26'sd7;
				5'd20: v = 26'sd4;
				5'd21: v = 26'sd2;
				5'd22: v = 26'sd1;
				default: v = '0;
			endcase
			return v;
		end
	endfunction

endpackage
`default_nettype wire

[sv/gof_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module gof_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

[sv/gradient_orientation_field.sv]
`timescale 1ns / 1ps
`default_nettype none
// Ridge orientation of a gradient image over a 16x16 window.
// Input words (req_type, grad_x, grad_y) arrive in raster order on a valid/ready
// channel; req_type=1 is a drain tick that flushes the end of the frame.
// Each pixel is written into a ring of 17 rows x 1024 columns in one RAM.
// The result for pixel p leaves with input word p + 8*W + 8. For such a word
// the block walks the 256 window positions through the RAM (one read a cycle),
// forms xx/yy/xy in a registered multiply stage and accumulates, then runs a
// 23-step iterative CORDIC (after 1 to 40 normalizing shifts) for the angle.
// Flow: a word that produces no result is accepted while the block stays idle;
// a word that produces one holds the input through the accept, the window walk
// and its read/multiply tail, the load, the normalizing shifts and a closing
// fold, the 23 CORDIC steps (all three skipped when the window sums cancel)
// and the load of the output register. in_ready is high only between words.
// Results sit in an output register: the block takes the next word while a
// result waits, and stalls only before loading a second result.
// Configuration (frame_width index 0, frame_height index 1) is written through
// cfg_write/cfg_index/cfg_data by the user only while idle; the block does not
// enforce this. A write to either index restarts the frame. Reset: counters cleared, 640x480 frame,
// no result pending. The RAM needs no clearing: only entries written in the current frame are ever read.
module gradient_orientation_field (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_write,
	input  logic [gof_pkg::CFG_IDX_BITS-1:0]       cfg_index,
	input  logic [gof_pkg::CFG_BITS-1:0]           cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic                                   req_type,
	input  logic signed [gof_pkg::SAMPLE_BITS-1:0] grad_x,
	input  logic signed [gof_pkg::SAMPLE_BITS-1:0] grad_y,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [15:0]                     angle,
	output logic signed [gof_pkg::SAMPLE_BITS-1:0] high_value,
	output logic signed [gof_pkg::SAMPLE_BITS-1:0] low_value,
	output logic signed [gof_pkg::SAMPLE_BITS-1:0] dominant_value,
	output logic                                   last_pixel
);
	import gof_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_SUM  = 6'b000010,
		S_LOAD = 6'b000100,
		S_NORM = 6'b001000,
		S_ROT  = 6'b010000,
		S_FIN  = 6'b100000
	} state_t;

	state_t state_q;

	logic [10:0] width_q;
	logic [12:0] height_q;
	logic [10:0] w_eff;
	logic [12:0] h_eff;
	logic [23:0] total;
	logic [13:0] delay;

	// input side counters
	logic [23:0]          n_q;
	logic [10:0]          n_col_q;
	logic [RING_BITS-1:0] n_ring_q;
	// output side counters
	logic [22:0]          p_q;
	logic [10:0]          p_col_q;
	logic [12:0]          p_row_q;
	logic [RING_BITS-1:0] p_ring_q;

	logic accept, n_lt_total, n_lt_delay;

	// window walk
	logic [8:0]           cnt_q;
	logic [RING_BITS-1:0] sum_ring_q;
	logic [RING_BITS-1:0] ring_start;
	logic                 issuing;
	logic signed [13:0]   rr;
	logic signed [11:0]   cc;
	logic                 pos_ok;
	logic                 ok_s1, center_s1, last_s1;
	logic                 ok_s2, last_s2;
	logic signed [31:0]   pxx_s2, pyy_s2, pxy_s2;
	logic signed [ACC_BITS-1:0] sxx_q, syy_q, sxy_q;
	logic signed [SAMPLE_BITS-1:0] cgx_q, cgy_q;

	// memory
	logic                 mem_we;
	logic [ADDR_BITS-1:0] mem_addr;
	logic [31:0]          mem_wdata, mem_rdata;
	logic signed [SAMPLE_BITS-1:0] rd_gx, rd_gy;

	// CORDIC
	logic signed [VEC_BITS-1:0] x_q, y_q;
	logic signed [ANG_BITS-1:0] z_q;
	logic [4:0]                 iter_q;
	logic                       zero_q;
	logic signed [VEC_BITS-1:0] norm_lim;
	logic                       vec_short;
	logic signed [VEC_BITS-1:0] x_nx, y_nx;
	logic signed [ANG_BITS-1:0] z_nx, z_wr, atan_i;
	logic signed [26:0]         z_rnd;
	logic signed [17:0]         th;
	logic signed [17:0]         ang_full;

	// result
	logic fin_load, is_last;
	logic signed [SAMPLE_BITS-1:0] hi, lo, dom;
	logic [SAMPLE_BITS:0] abs_hi, abs_lo;

	// frame geometry
	always_comb begin
		if (width_q == 11'd0) begin
			w_eff = 11'd1;
		end else if (width_q > 11'(MAX_WIDTH)) begin
			w_eff = 11'(MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
		h_eff = (height_q == 13'd0) ? 13'd1 : height_q;
	end
	assign total      = {13'b0, w_eff} * {11'b0, h_eff};
	assign delay      = 14'({w_eff, 3'b000}) + 14'd8;
	assign n_lt_total = n_q < total;
	assign n_lt_delay = n_q < {10'b0, delay};

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	// window position of the current read
	assign issuing = (state_q == S_SUM) && !cnt_q[8];
	assign rr = $signed({1'b0, p_row_q}) - 14'sd7 + $signed({10'b0, cnt_q[7:4]});
	assign cc = $signed({1'b0, p_col_q}) - 12'sd7 + $signed({8'b0, cnt_q[3:0]});
	assign pos_ok = !rr[13] && (rr[12:0] < h_eff) && !cc[11] && (cc[10:0] < w_eff);
	assign ring_start = (p_ring_q >= 5'd7) ? p_ring_q - 5'd7 : p_ring_q + 5'd10;

	assign mem_we    = accept && n_lt_total;
	assign mem_addr  = mem_we ? {n_ring_q, n_col_q[COL_BITS-1:0]}
	                          : {sum_ring_q, cc[COL_BITS-1:0]};
	assign mem_wdata = req_type ? 32'd0 : {grad_y, grad_x};
	assign rd_gx     = mem_rdata[15:0];
	assign rd_gy     = mem_rdata[31:16];

	gof_ram #(
		.WIDTH (32),
		.DEPTH (STORE_DEPTH)
	) u_row_store (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// multiply stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_s1     <= 1'b0;
			center_s1 <= 1'b0;
			last_s1   <= 1'b0;
			ok_s2     <= 1'b0;
			last_s2   <= 1'b0;
		end else begin
			ok_s1     <= issuing && pos_ok;
			center_s1 <= issuing && (cnt_q[7:0] == 8'h77);
			last_s1   <= issuing && (cnt_q[7:0] == 8'hFF);
			ok_s2     <= ok_s1;
			last_s2   <= last_s1;
		end
	end

	always_ff @(posedge clk) begin
		pxx_s2 <= rd_gx * rd_gx;
		pyy_s2 <= rd_gy * rd_gy;
		pxy_s2 <= rd_gx * rd_gy;
		if (center_s1) begin
			cgx_q <= rd_gx;
			cgy_q <= rd_gy;
		end
	end

	// CORDIC datapath
	assign norm_lim = 45'sh100_0000_0000;
	assign vec_short = (x_q < norm_lim) && (x_q > -norm_lim)
	                && (y_q < norm_lim) && (y_q > -norm_lim);
	assign atan_i = atan_entry(iter_q);

	always_comb begin
		if (!y_q[VEC_BITS-1]) begin
			x_nx = x_q + (y_q >>> iter_q);
			y_nx = y_q - (x_q >>> iter_q);
			z_nx = z_q + atan_i;
		end else begin
			x_nx = x_q - (y_q >>> iter_q);
			y_nx = y_q + (x_q >>> iter_q);
			z_nx = z_q - atan_i;
		end
	end

	// wrap to (-180,180], halve with rounding, turn by 90 degrees
	always_comb begin
		if (z_q <= -DEG180_U) begin
			z_wr = z_q + DEG360_U;
		end else if (z_q > DEG180_U) begin
			z_wr = z_q - DEG360_U;
		end else begin
			z_wr = z_q;
		end
		z_rnd = 27'(z_wr) + 27'sd256;
		th    = 18'(z_rnd >>> 9);
		ang_full = (th <= 18'sd0) ? th + OUT90 : th - OUT90;
	end

	// pair ordering of the center pixel
	always_comb begin
		if (cgx_q >= cgy_q) begin
			hi = cgx_q;
			lo = cgy_q;
		end else begin
			hi = cgy_q;
			lo = cgx_q;
		end
		abs_hi = hi[SAMPLE_BITS-1] ? 17'(-$signed({hi[SAMPLE_BITS-1], hi})) : 17'(hi);
		abs_lo = lo[SAMPLE_BITS-1] ? 17'(-$signed({lo[SAMPLE_BITS-1], lo})) : 17'(lo);
		dom = (abs_hi > abs_lo) ? hi : lo;
	end

	assign fin_load = (state_q == S_FIN) && (!out_valid || out_ready);
	assign is_last  = ({1'b0, p_q} + 24'd1) >= total;

	// control, counters, accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			width_q    <= 11'd640;
			height_q   <= 13'd480;
			n_q        <= '0;
			n_col_q    <= '0;
			n_ring_q   <= '0;
			p_q        <= '0;
			p_col_q    <= '0;
			p_row_q    <= '0;
			p_ring_q   <= '0;
			cnt_q      <= '0;
			sum_ring_q <= '0;
			iter_q     <= '0;
			zero_q     <= 1'b0;
			out_valid  <= 1'b0;
		end else begin
			if (fin_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end

			if (cfg_write) begin
				if (cfg_index == CFG_FRAME_WIDTH) begin
					width_q <= cfg_data[10:0];
				end
				if (cfg_index == CFG_FRAME_HEIGHT) begin
					height_q <= cfg_data;
				end
				if (cfg_index == CFG_FRAME_WIDTH || cfg_index == CFG_FRAME_HEIGHT) begin
					n_q      <= '0;
					n_col_q  <= '0;
					n_ring_q <= '0;
					p_q      <= '0;
					p_col_q  <= '0;
					p_row_q  <= '0;
					p_ring_q <= '0;
				end
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						n_q <= n_q + 24'd1;
						if (n_col_q + 11'd1 >= w_eff) begin
							n_col_q  <= '0;
							n_ring_q <= (n_ring_q == 5'(RING_ROWS - 1)) ? '0 : n_ring_q + 5'd1;
						end else begin
							n_col_q <= n_col_q + 11'd1;
						end
						if (!n_lt_delay) begin
							state_q    <= S_SUM;
							cnt_q      <= '0;
							sum_ring_q <= ring_start;
						end
					end
				end
				S_SUM: begin
					if (issuing) begin
						cnt_q <= cnt_q + 9'd1;
						if (cnt_q[3:0] == 4'hF) begin
							sum_ring_q <= (sum_ring_q == 5'(RING_ROWS - 1)) ? '0
							            : sum_ring_q + 5'd1;
						end
					end
					if (last_s2) begin
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					zero_q  <= (sxx_q == syy_q) && (sxy_q == '0);
					state_q <= S_NORM;
				end
				S_NORM: begin
					if (zero_q) begin
						state_q <= S_FIN;
					end else if (!vec_short) begin
						iter_q  <= '0;
						state_q <= S_ROT;
					end
				end
				S_ROT: begin
					iter_q <= iter_q + 5'd1;
					if (iter_q == 5'(CORDIC_STEPS - 1)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (fin_load) begin
						state_q <= S_IDLE;
						if (is_last) begin
							n_q      <= '0;
							n_col_q  <= '0;
							n_ring_q <= '0;
							p_q      <= '0;
							p_col_q  <= '0;
							p_row_q  <= '0;
							p_ring_q <= '0;
						end else begin
							p_q <= p_q + 23'd1;
							if (p_col_q + 11'd1 >= w_eff) begin
								p_col_q  <= '0;
								p_row_q  <= p_row_q + 13'd1;
								p_ring_q <= (p_ring_q == 5'(RING_ROWS - 1)) ? '0
								          : p_ring_q + 5'd1;
							end else begin
								p_col_q <= p_col_q + 11'd1;
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			sxx_q <= '0;
			syy_q <= '0;
			sxy_q <= '0;
		end else if (state_q == S_SUM && ok_s2) begin
			sxx_q <= sxx_q + 40'(pxx_s2);
			syy_q <= syy_q + 40'(pyy_s2);
			sxy_q <= sxy_q + 40'(pxy_s2);
		end

		if (state_q == S_LOAD) begin
			x_q <= 45'(sxx_q) - 45'(syy_q);
			y_q <= 45'($signed({sxy_q, 1'b0}));
			z_q <= '0;
		end else if (state_q == S_NORM && !zero_q) begin
			if (vec_short) begin
				x_q <= x_q <<< 1;
				y_q <= y_q <<< 1;
			end else if (x_q[VEC_BITS-1]) begin
				if (!y_q[VEC_BITS-1]) begin
					x_q <= y_q;
					y_q <= -x_q;
					z_q <= DEG90_U;
				end else begin
					x_q <= -y_q;
					y_q <= x_q;
					z_q <= -DEG90_U;
				end
			end
		end else if (state_q == S_ROT) begin
			x_q <= x_nx;
			y_q <= y_nx;
			z_q <= z_nx;
		end

		if (fin_load) begin
			angle          <= zero_q ? 16'sd0 : 16'(ang_full);
			high_value     <= hi;
			low_value      <= lo;
			dominant_value <= dom;
			last_pixel     <= is_last;
		end
	end

	// memory is written only between words, never during the window walk
	a_we_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_IDLE && !issuing))
		else $error("row store written during window walk");

	a_iter_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROT) |-> (iter_q <= 5'(CORDIC_STEPS - 1)))
		else $error("CORDIC step count out of range");

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_load && is_last) |=> (n_q == '0 && p_q == '0))
		else $error("counters not cleared after last pixel");

	a_p_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SUM) |-> ({1'b0, p_q} < total))
		else $error("output pixel beyond frame");

	a_walk_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOAD) |-> (cnt_q == 9'd256))
		else $error("window walk incomplete");
endmodule
`default_nettype wire
